// File: hw/rtl/text_console_writer_macros.svh
// assertion helpers for the console rtl
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tcw assertion failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tcw assertion failed");

`endif

// File: hw/rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELLS         = ROWS * COLUMNS;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W        = $clog2(CELLS);
  localparam int COL_W         = $clog2(COLUMNS + 1);
  localparam int ROW_W         = $clog2(ROWS + 1);
  localparam int TAB_COL       = 3;

  localparam int CELL_W    = 16;
  localparam int CODE_W    = 8;
  localparam int IDX_W     = 11;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;
  localparam int ATTR_W    = 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_ATTR = '0;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CODE_W-1:0] CH_BS    = 8'd8;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CODE_W-1:0] CH_NL    = 8'd10;
  localparam logic [CODE_W-1:0] CH_VT    = 8'd11;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_UNDER = 8'h5F;

  localparam logic [CELL_W-1:0] PROMPT_DOLLAR = 16'h0C24;
  localparam logic [CELL_W-1:0] PROMPT_COLON  = 16'h0F3A;
  localparam logic [CELL_W-1:0] PROMPT_SPACE  = 16'h0020;

  typedef struct packed {
    logic [2:0][ADDR_W-1:0] wa;
    logic [2:0][CELL_W-1:0] wd;
    logic [1:0]             wlast;
    logic [COL_W-1:0]       ncol;
    logic [ROW_W-1:0]       nline;
    logic                   clear;
    logic                   scroll;
  } plan_t;

endpackage

// File: hw/rtl/tcw_if.sv
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [CODE_W-1:0] char_code;
  logic              starts_string;
  logic [IDX_W-1:0]  cell_index;

  modport source(output valid, output operation, output char_code,
                 output starts_string, output cell_index, input ready);
  modport sink(input valid, input operation, input char_code,
               input starts_string, input cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CELL_W-1:0]    cell_value;
  logic [OUT_COL_W-1:0] cursor_column;
  logic [OUT_ROW_W-1:0] cursor_row;

  modport source(output valid, output cell_value, output cursor_column,
                 output cursor_row, input ready);
  modport sink(input valid, input cell_value, input cursor_column,
               input cursor_row, output ready);
endinterface

// File: hw/rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/tcw_decode.sv
module tcw_decode import tcw_pkg::*; (
  input  logic [CODE_W-1:0] char_code,
  input  logic              starts_string,
  input  logic [COL_W-1:0]  col,
  input  logic [ROW_W-1:0]  line,
  input  logic [ATTR_W-1:0] attr,
  output plan_t             plan
);

  logic [ADDR_W-1:0] row0;
  logic [ADDR_W-1:0] here;
  logic              at_home;

  assign row0    = ADDR_W'(line * COLUMNS);
  assign here    = row0 + ADDR_W'(col);
  assign at_home = (line == '0) && (col == '0);

  always_comb begin
    plan        = '0;
    plan.ncol   = col;
    plan.nline  = line;
    plan.wa[0]  = here;
    plan.wd[0]  = {attr, char_code};
    unique case (char_code)
      CH_BS: begin
        plan.wd[0] = {attr, CH_SPACE};
        if (!at_home) begin
          plan.wlast = 2'd1;
          plan.wa[1] = here - ADDR_W'(1);
          plan.wd[1] = {attr, CH_UNDER};
          if (col != '0) begin
            plan.ncol = col - COL_W'(1);
          end else begin
            plan.nline = line - ROW_W'(1);
            plan.ncol  = COL_W'(COLUMNS - 1);
          end
        end
      end
      CH_NL: begin
        plan.wd[0] = {attr, CH_SPACE};
        plan.nline = line + ROW_W'(1);
        plan.ncol  = '0;
      end
      CH_TAB: begin
        if (starts_string) begin
          // shell prompt at the start of the row
          plan.wlast = 2'd2;
          plan.wa[0] = row0;
          plan.wa[1] = row0 + ADDR_W'(1);
          plan.wa[2] = row0 + ADDR_W'(2);
          plan.wd[0] = PROMPT_DOLLAR;
          plan.wd[1] = PROMPT_COLON;
          plan.wd[2] = PROMPT_SPACE;
          if (col < COL_W'(TAB_COL)) begin
            plan.ncol = COL_W'(TAB_COL);
          end
        end else begin
          plan.wd[0] = {attr, CH_UNDER};
        end
      end
      CH_VT: begin
        plan.clear = 1'b1;
        plan.ncol  = '0;
        plan.nline = '0;
      end
      default: begin
        plan.ncol = col + COL_W'(1);
      end
    endcase
    if (plan.ncol >= COL_W'(COLUMNS)) begin
      plan.ncol  = '0;
      plan.nline = plan.nline + ROW_W'(1);
    end
    if (plan.nline >= ROW_W'(ROWS)) begin
      plan.scroll = 1'b1;
      plan.nline  = ROW_W'(ROWS - 1);
      plan.ncol   = '0;
    end
  end

endmodule

// File: hw/rtl/text_console_writer.sv
// channel    dir  handshake      payload
// in_chan    in   valid/ready    operation, char_code, starts_string, cell_index
// out_chan   out  valid/ready    cell_value, cursor_column, cursor_row
// cfg_*      in   apb write/read text_attribute at byte address 0
//
// a read passes ST_RDATA then ST_DONE; a put writes one to three screen cells in ST_WRITE
// a scroll then copies every row up and fills the last row, a vertical tab clears all cells,
// both paced cell by cell through the single write port of the screen memory
// after reset a clearing pass over all rows*columns cells (2000) holds in_chan.ready low
// a result waits in the output register; the next item is taken meanwhile
`include "text_console_writer_macros.svh"

module text_console_writer import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_in_if.sink                in_chan,
  tcw_out_if.source             out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDATA = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_CLEAR = 3'd3;
  localparam logic [2:0] ST_COPY  = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]           state_r;
  logic [ADDR_W-1:0]    cnt_r;
  logic [1:0]           step_r;
  logic                 item_r;
  logic                 in_range_r;
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     line_r;
  logic [ATTR_W-1:0]    attr_r;
  logic [CELL_W-1:0]    res_val_r;
  plan_t                plan_r;
  logic                 out_valid_r;
  logic [CELL_W-1:0]    out_val_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic [OUT_ROW_W-1:0] out_row_r;

  plan_t             plan;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic              cfg_wr;
  logic              attr_sel;
  logic              out_load;

  tcw_decode u_decode (
    .char_code     (in_chan.char_code),
    .starts_string (in_chan.starts_string),
    .col           (col_r),
    .line          (line_r),
    .attr          (attr_r),
    .plan          (plan)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = ADDR_W'(in_chan.cell_index);
      end
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = plan_r.wa[step_r];
        ram_wdata = plan_r.wd[step_r];
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_COPY: begin
        // read one row ahead, write the cell read last cycle
        ram_we    = (cnt_r != '0);
        ram_waddr = cnt_r - ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (cnt_r != ADDR_W'(LAST_ROW_BASE)) begin
          ram_raddr = cnt_r + ADDR_W'(COLUMNS);
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {attr_r, CH_SPACE};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign in_chan.ready = (state_r == ST_IDLE);
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      step_r  <= '0;
      item_r  <= 1'b0;
      col_r   <= '0;
      line_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            item_r    <= 1'b1;
            res_val_r <= '0;
            if (in_chan.operation == OP_READ) begin
              in_range_r <= (in_chan.cell_index < CELLS);
              state_r    <= ST_RDATA;
            end else begin
              plan_r <= plan;
              col_r  <= plan.ncol;
              line_r <= plan.nline;
              step_r <= '0;
              cnt_r  <= '0;
              state_r <= plan.clear ? ST_CLEAR : ST_WRITE;
            end
          end
        end
        ST_RDATA: begin
          res_val_r <= in_range_r ? ram_rdata : '0;
          state_r   <= ST_DONE;
        end
        ST_WRITE: begin
          if (step_r == plan_r.wlast) begin
            cnt_r   <= '0;
            state_r <= plan_r.scroll ? ST_COPY : ST_DONE;
          end else begin
            step_r <= step_r + 2'd1;
          end
        end
        ST_CLEAR: begin
          if (cnt_r == ADDR_W'(CELLS - 1)) begin
            state_r <= item_r ? ST_DONE : ST_IDLE;
          end else begin
            cnt_r <= cnt_r + ADDR_W'(1);
          end
        end
        ST_COPY: begin
          if (cnt_r == ADDR_W'(LAST_ROW_BASE)) begin
            state_r <= ST_FILL;
          end else begin
            cnt_r <= cnt_r + ADDR_W'(1);
          end
        end
        ST_FILL: begin
          if (cnt_r == ADDR_W'(CELLS - 1)) begin
            state_r <= ST_DONE;
          end else begin
            cnt_r <= cnt_r + ADDR_W'(1);
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_val_r <= res_val_r;
            out_col_r <= OUT_COL_W'(col_r);
            out_row_r <= OUT_ROW_W'(line_r);
            item_r    <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.cell_value    = out_val_r;
  assign out_chan.cursor_column = out_col_r;
  assign out_chan.cursor_row    = out_row_r;

  // configuration
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign attr_sel   = (cfg_paddr[CFG_ADDR_W-1:2] == REG_ATTR);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = attr_sel ? CFG_DATA_W'(attr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_wr && attr_sel) begin
      attr_r <= cfg_pwdata[ATTR_W-1:0];
    end
  end

  `TCW_ASSERT_IMPLY(a_col_range, clk, rst_n, 1'b1, col_r < COLUMNS)
  `TCW_ASSERT_IMPLY(a_line_range, clk, rst_n, 1'b1, line_r < ROWS)
  `TCW_ASSERT_IMPLY(a_wr_range, clk, rst_n, ram_we, ram_waddr < CELLS)
  `TCW_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready)

endmodule

// File: sim/text_console_writer_checker.sv
module text_console_writer_checker import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_in_if                     in_mon,
  tcw_out_if                    out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    failures,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_val;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
  } cursor_report_t;

  logic [CELL_W-1:0] screen [CELLS];
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ATTR_W-1:0] text_attr;
  cursor_report_t    cursor_reports_q [$];

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  function automatic logic [CELL_W-1:0] tinted(logic [CODE_W-1:0] ch);
    return {text_attr, ch};
  endfunction

  function automatic void wipe_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = '0;
    cur_col = '0;
    cur_row = '0;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < LAST_ROW_BASE; i++) screen[i] = screen[i + COLUMNS];
    for (int i = 0; i < COLUMNS; i++) screen[LAST_ROW_BASE + i] = tinted(CH_SPACE);
  endfunction

  function automatic void put_glyph(logic [CODE_W-1:0] code, logic first);
    int here;
    int row_base;
    here     = int'(cur_row) * COLUMNS + int'(cur_col);
    row_base = int'(cur_row) * COLUMNS;
    case (code)
      CH_BS: begin
        screen[here] = tinted(CH_SPACE);
        if (here > 0) begin
          screen[here - 1] = tinted(CH_UNDER);
          if (cur_col > 0) begin
            cur_col = cur_col - 1'b1;
          end else begin
            cur_row = cur_row - 1'b1;
            cur_col = COL_W'(COLUMNS - 1);
          end
        end
      end
      CH_NL: begin
        screen[here] = tinted(CH_SPACE);
        cur_row = cur_row + 1'b1;
        cur_col = '0;
      end
      CH_TAB: begin
        if (first) begin
          if (cur_col < TAB_COL) cur_col = COL_W'(TAB_COL);
          screen[row_base]     = PROMPT_DOLLAR;
          screen[row_base + 1] = PROMPT_COLON;
          screen[row_base + 2] = PROMPT_SPACE;
        end else begin
          screen[here] = tinted(CH_UNDER);
        end
      end
      CH_VT: wipe_screen();
      default: begin
        screen[here] = tinted(code);
        cur_col = cur_col + 1'b1;
      end
    endcase
    if (cur_col >= COLUMNS) begin
      cur_row = cur_row + 1'b1;
      cur_col = '0;
    end
    if (cur_row >= ROWS) begin
      scroll_screen();
      cur_col = '0;
      cur_row = ROW_W'(ROWS - 1);
    end
  endfunction

  function automatic cursor_report_t console_step(logic op, logic [CODE_W-1:0] code,
                                                  logic first, logic [IDX_W-1:0] idx);
    cursor_report_t r;
    r.cell_val = '0;
    if (op == OP_READ) begin
      if (idx < CELLS) r.cell_val = screen[idx];
    end else begin
      put_glyph(code, first);
    end
    r.col = OUT_COL_W'(cur_col);
    r.row = OUT_ROW_W'(cur_row);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    failures++;
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    cursor_report_t want;
    if (!rst_n) begin
      wipe_screen();
      text_attr = ATTR_RESET;
      cursor_reports_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (cursor_reports_q.size() == 0) begin
          report_mismatch("result with no transaction pending", out_mon.cell_value, 0);
        end else begin
          want = cursor_reports_q.pop_front();
          if (out_mon.cell_value !== want.cell_val)
            report_mismatch("cell_value", out_mon.cell_value, want.cell_val);
          if (out_mon.cursor_column !== want.col)
            report_mismatch("cursor_column", out_mon.cursor_column, want.col);
          if (out_mon.cursor_row !== want.row)
            report_mismatch("cursor_row", out_mon.cursor_row, want.row);
        end
      end
      if (in_mon.valid && in_mon.ready)
        cursor_reports_q.push_back(console_step(in_mon.operation, in_mon.char_code,
                                                in_mon.starts_string, in_mon.cell_index));
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[CFG_ADDR_W-1:2] == REG_ATTR) begin
        if (cfg_pwrite) begin
          text_attr = cfg_pwdata[ATTR_W-1:0];
        end else if (cfg_prdata !== CFG_DATA_W'(text_attr)) begin
          report_mismatch("text_attribute readback", cfg_prdata, text_attr);
        end
      end
    end
    outstanding = cursor_reports_q.size();
  end

endmodule

// File: sim/text_console_writer_tb.sv
module text_console_writer_tb;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD       = 10;
  localparam int RANDOM_ITEMS = 1050;
  localparam int CYCLE_LIMIT  = 12_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDX_TOP      = (1 << IDX_W) - 1;

  typedef enum int {SEQ_LINE, SEQ_READS, SEQ_ERASE, SEQ_NOISE, SEQ_CLEAR, SEQ_SCROLL} seq_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int failures;
  int outstanding;
  int items_sent    = 0;
  int results_taken = 0;
  int cycles        = 0;
  bit steady        = 1'b0;

  tcw_in_if  in_chan ();
  tcw_out_if out_chan ();

  text_console_writer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  text_console_writer_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .failures   (failures),
    .outstanding(outstanding)
  );

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) results_taken <= results_taken + 1;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CODE_W-1:0] pick_glyph();
    logic [CODE_W-1:0] c;
    c = CODE_W'($urandom_range(0, 255));
    while (c >= CH_BS && c <= CH_VT) c = CODE_W'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic send_item(logic op, logic [CODE_W-1:0] code, logic first,
                           logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.operation     <= op;
    in_chan.char_code     <= code;
    in_chan.starts_string <= first;
    in_chan.cell_index    <= idx;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put(logic [CODE_W-1:0] code, logic first);
    send_item(OP_PUT, code, first, IDX_W'($urandom_range(0, IDX_TOP)));
  endtask

  task automatic read_cell(int idx);
    send_item(OP_READ, CODE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              IDX_W'(idx));
  endtask

  // write then read back, psel held across both transactions
  task automatic set_attribute(logic [ATTR_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_ATTR, 2'b00};
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic run_sequence(seq_kind_t kind);
    int n;
    int r;
    case (kind)
      SEQ_LINE: begin
        if ($urandom_range(0, 1)) put(CH_TAB, 1'b1);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 30);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 8) put(CH_BS, 1'($urandom_range(0, 1)));
          else if (r < 11) put(CH_TAB, 1'b0);
          else if (r < 13) put(CH_TAB, 1'b1);
          else put(pick_glyph(), 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 4) != 0) put(CH_NL, 1'($urandom_range(0, 1)));
      end
      SEQ_READS: begin
        repeat ($urandom_range(1, 8)) begin
          r = $urandom_range(0, 99);
          if (r < 80) read_cell($urandom_range(0, CELLS - 1));
          else if (r < 90) read_cell($urandom_range(CELLS, IDX_TOP));
          else if (r < 93) read_cell(0);
          else if (r < 96) read_cell(COLUMNS - 1);
          else if (r < 98) read_cell(LAST_ROW_BASE);
          else read_cell(CELLS - 1);
        end
      end
      SEQ_ERASE: begin
        put(CH_NL, 1'b0);
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) put(pick_glyph(), 1'b0);
          put(CH_BS, 1'($urandom_range(0, 1)));
        end
      end
      SEQ_NOISE: begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, IDX_TOP)));
      end
      SEQ_CLEAR: begin
        put(CH_VT, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 10)) put(pick_glyph(), 1'b0);
      end
      default: begin
        repeat ($urandom_range(26, 30)) begin
          put(CH_NL, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 2) == 0) put(pick_glyph(), 1'b0);
        end
      end
    endcase
  endtask

  function automatic seq_kind_t pick_kind(int seq_no);
    int r;
    if (seq_no == 3) return SEQ_SCROLL;
    r = $urandom_range(0, 99);
    if (r < 40) return SEQ_LINE;
    if (r < 65) return SEQ_READS;
    if (r < 80) return SEQ_ERASE;
    if (r < 93) return SEQ_NOISE;
    if (r < 97) return SEQ_CLEAR;
    return SEQ_SCROLL;
  endfunction

  // result side: random ready with one long hold-off once traffic is flowing
  initial begin
    int run;
    int gap;
    bit held;
    held = 1'b0;
    out_chan.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!held && results_taken >= 150) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      run = $urandom_range(1, 40);
      out_chan.ready <= 1'b1;
      repeat (run) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("text_console_writer_tb: FAIL");
    $finish;
  end

  initial begin
    logic [ATTR_W-1:0] attrs [4];
    int seq_no;
    int base;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.operation     = OP_PUT;
    in_chan.char_code     = '0;
    in_chan.starts_string = 1'b0;
    in_chan.cell_index    = '0;
    cfg_psel              = 1'b0;
    cfg_penable           = 1'b0;
    cfg_pwrite            = 1'b0;
    cfg_paddr             = '0;
    cfg_pwdata            = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset attribute
    put(CH_BS, 1'b0);
    read_cell(0);
    put(CH_TAB, 1'b1);
    read_cell(0);
    read_cell(1);
    read_cell(2);
    put(8'hFF, 1'b0);
    put(CH_TAB, 1'b0);
    put(8'h00, 1'b1);
    put(CH_NL, 1'b0);
    put(CH_BS, 1'b0);
    read_cell(COLUMNS - 1);
    put(8'h41, 1'b0);
    put(CH_TAB, 1'b1);
    put(8'h7E, 1'b0);
    put(CH_TAB, 1'b1);
    read_cell(COLUMNS);
    put(CH_VT, 1'b0);
    read_cell(CELLS - 1);
    read_cell(CELLS);
    read_cell(IDX_TOP);

    attrs[0] = 8'hFF;
    attrs[1] = ATTR_W'($urandom_range(1, 254));
    attrs[2] = 8'h00;
    attrs[3] = ATTR_W'($urandom_range(0, 255));
    base     = items_sent;
    seq_no   = 0;
    for (int p = 0; p < 4; p++) begin
      in_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clk);
      set_attribute(attrs[p]);
      while (items_sent - base < (p + 1) * RANDOM_ITEMS / 4) begin
        steady = ($urandom_range(0, 4) == 0);
        run_sequence(pick_kind(seq_no));
        seq_no++;
      end
    end
    in_chan.valid <= 1'b0;
    steady = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (2100) @(negedge clk);
    if (failures == 0)
      $display("text_console_writer_tb: PASS");
    else
      $display("text_console_writer_tb: FAIL");
    $finish;
  end

endmodule
